// File: rtl/core/assert_macros.svh
// Assertion shorthands used by the top-level detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFPV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KFPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/kfpv_pkg.sv
`timescale 1ns / 1ps
package kfpv_pkg;

  localparam int CHANNEL_BITS  = 4;
  localparam int CFG_BITS      = 10;
  localparam int CFG_IDX_BITS  = 1;
  localparam int VEL_BITS      = 7;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET    = 1'd1;

  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 10'd275;
  localparam logic [CFG_BITS-1:0] OFFSET_RESET    = 10'd247;

  localparam logic [VEL_BITS-1:0] VEL_MAX = 7'd127;

  // Differences at or above this saturate the velocity: 3 * (VEL_MAX + 1).
  localparam int VEL_SAT_LIMIT = 3 * (int'(VEL_MAX) + 1);
  // Below the saturation limit the difference fits in nine bits, where
  // floor(x / 3) equals (x * 171) >> 9 exactly.
  localparam int DIV3_IN_BITS = 9;
  localparam int DIV3_MUL     = 171;
  localparam int DIV3_SHIFT   = 9;
  localparam int DIV3_MUL_BITS = 8;

endpackage

// File: rtl/core/kfpv_channels.sv
`timescale 1ns / 1ps
// Sample channel: one key channel number and one force reading per item.
interface kfpv_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                              valid;
  logic                              ready;
  logic [kfpv_pkg::CHANNEL_BITS-1:0] channel;
  logic [SAMPLE_BITS-1:0]            sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// Note-on channel: one detected peak per item.
interface kfpv_out_if;
  logic                              valid;
  logic                              ready;
  logic [kfpv_pkg::CHANNEL_BITS-1:0] note_number;
  logic [kfpv_pkg::VEL_BITS-1:0]     note_velocity;

  modport source (output valid, output note_number, output note_velocity, input ready);
  modport sink   (input valid, input note_number, input note_velocity, output ready);
endinterface

// File: rtl/core/kfpv_velocity.sv
`timescale 1ns / 1ps
module kfpv_velocity #(
  parameter int CMP_W = 10
) (
  input  logic [CMP_W-1:0]             peak_i,
  input  logic [kfpv_pkg::CFG_BITS-1:0] offset_i,
  output logic [kfpv_pkg::VEL_BITS-1:0] velocity_o
);
  import kfpv_pkg::*;

  localparam int PROD_W = DIV3_IN_BITS + DIV3_MUL_BITS;

  logic [CMP_W-1:0]  offset_ext;
  logic [CMP_W-1:0]  diff;
  logic [PROD_W-1:0] prod;

  assign offset_ext = CMP_W'(offset_i);
  assign diff       = peak_i - offset_ext;
  assign prod       = PROD_W'(diff[DIV3_IN_BITS-1:0]) * PROD_W'(DIV3_MUL);

  always_comb begin
    if (peak_i <= offset_ext) begin
      velocity_o = '0;
    end else if (diff >= CMP_W'(VEL_SAT_LIMIT)) begin
      velocity_o = VEL_MAX;
    end else begin
      velocity_o = prod[DIV3_SHIFT +: VEL_BITS];
    end
  end

endmodule

// File: rtl/core/kfpv_track.sv
`timescale 1ns / 1ps
module kfpv_track #(
  parameter int CHANNEL_COUNT = 16,
  parameter int SAMPLE_BITS   = 10,
  parameter int CMP_W         = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              update_i,
  input  logic [kfpv_pkg::CHANNEL_BITS-1:0] channel_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic [kfpv_pkg::CFG_BITS-1:0]     threshold_i,
  output logic                              fire_o,
  output logic [CMP_W-1:0]                  peak_o
);
  import kfpv_pkg::*;

  // Only channels that the channel field can name need storage.
  localparam int MAX_CH = 1 << CHANNEL_BITS;
  localparam int DEPTH  = (CHANNEL_COUNT < MAX_CH) ? CHANNEL_COUNT : MAX_CH;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SAMPLE_BITS-1:0] force_q  [DEPTH];
  logic [DEPTH-1:0]       rising_q;
  logic [DEPTH-1:0]       wait_q;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [CMP_W-1:0] sample_ext;
  logic [CMP_W-1:0] prev_ext;
  logic [CMP_W-1:0] thr_ext;
  logic             rising;
  logic             peak_found;
  logic             release_seen;

  assign in_range     = 32'(channel_i) < 32'(CHANNEL_COUNT);
  assign idx          = channel_i[IDX_W-1:0];
  assign sample_ext   = CMP_W'(sample_i);
  assign thr_ext      = CMP_W'(threshold_i);
  assign prev_ext     = in_range ? CMP_W'(force_q[idx]) : '0;
  assign rising       = sample_ext > prev_ext;
  assign release_seen = sample_ext < thr_ext;
  // A turn from rising to not rising with the previous sample above threshold.
  assign peak_found   = in_range && !wait_q[idx] && rising_q[idx] && !rising
                        && (prev_ext > thr_ext);

  assign fire_o = update_i && peak_found;
  assign peak_o = prev_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        force_q[i] <= '0;
      end
      rising_q <= '0;
      wait_q   <= '0;
    end else if (update_i && in_range) begin
      if (wait_q[idx]) begin
        if (release_seen) begin
          wait_q[idx] <= 1'b0;
        end
      end else begin
        force_q[idx]  <= sample_i;
        rising_q[idx] <= rising;
        if (peak_found) begin
          wait_q[idx] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/key_force_peak_velocity_detector.sv
`timescale 1ns / 1ps
// Path: an accepted sample is held in the input register; the per-channel read-modify-write
// and velocity math then feed the output register, which takes a note-on item when a peak is found.
// Throughput: one sample per cycle unless the output is held; channel state is read combinationally and written back.
// Reset: asynchronous, active low; all channels armed with cleared history, threshold 275
// and offset 247.
`include "assert_macros.svh"
module key_force_peak_velocity_detector #(
  parameter int CHANNEL_COUNT = 16,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kfpv_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [kfpv_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  kfpv_in_if.sink                             in_s,
  kfpv_out_if.source                          out_m
);
  import kfpv_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

  logic [CFG_BITS-1:0]     threshold_q;
  logic [CFG_BITS-1:0]     offset_q;

  logic                    s1_valid_q;
  logic [CHANNEL_BITS-1:0] s1_channel_q;
  logic [SAMPLE_BITS-1:0]  s1_sample_q;

  logic                    out_valid_q;
  logic [CHANNEL_BITS-1:0] out_number_q;
  logic [VEL_BITS-1:0]     out_velocity_q;

  logic                    advance;
  logic                    in_ready;
  logic                    fire;
  logic [CMP_W-1:0]        peak;
  logic [VEL_BITS-1:0]     velocity;

  // The second stage moves whenever the output register is free or being emptied.
  assign advance  = !out_valid_q || out_m.ready;
  assign in_ready = !s1_valid_q || advance;

  assign in_s.ready          = in_ready;
  assign out_m.valid         = out_valid_q;
  assign out_m.note_number   = out_number_q;
  assign out_m.note_velocity = out_velocity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      offset_q    <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_wdata_i;
        CFG_OFFSET:    offset_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_s.valid) begin
      s1_channel_q <= in_s.channel;
      s1_sample_q  <= in_s.sample;
    end
  end

  kfpv_track #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .CMP_W         (CMP_W)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (s1_valid_q && advance),
    .channel_i   (s1_channel_q),
    .sample_i    (s1_sample_q),
    .threshold_i (threshold_q),
    .fire_o      (fire),
    .peak_o      (peak)
  );

  kfpv_velocity #(
    .CMP_W (CMP_W)
  ) u_velocity (
    .peak_i     (peak),
    .offset_i   (offset_q),
    .velocity_o (velocity)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire) begin
      out_number_q   <= s1_channel_q;
      out_velocity_q <= velocity;
    end
  end

  `KFPV_ASSERT_NEXT(a_fire_reaches_output, clk_i, rst_ni, fire, out_valid_q, "peak event did not reach the output register")
  `KFPV_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni, out_valid_q && !out_m.ready && s1_valid_q, !in_s.ready, "input accepted while both stages are held")
  `KFPV_ASSERT_IMPL(a_fire_above_threshold, clk_i, rst_ni, fire, peak > CMP_W'(threshold_q), "peak event at or below threshold")
  `KFPV_ASSERT_IMPL(a_fire_needs_item, clk_i, rst_ni, fire, s1_valid_q && advance, "peak event without a moving item")

endmodule
